### sv/hvt_pkg.sv
`timescale 1ns / 1ps
// hvt_pkg: types, codes and character classes for the header value tokenizer
// no dependencies; imported by hvt top level and checker

package hvt_pkg;

  localparam int unsigned POS_BITS_DEF = 16;
  localparam int unsigned SPAN_W       = 16;
  localparam int unsigned RQ_DEPTH     = 4;
  localparam int unsigned RQ_PTR_W     = $clog2(RQ_DEPTH);
  localparam int unsigned RQ_CNT_W     = RQ_PTR_W + 1;
  localparam int unsigned M_TDATA_W    = 40;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_WS    = 3'd1,
    MODE_IDENT = 3'd2,
    MODE_STR   = 3'd3,
    MODE_ESC   = 3'd4,
    MODE_SKIP  = 3'd5
  } lex_mode_e;

  typedef enum logic [2:0] {
    KIND_WS    = 3'd0,
    KIND_IDENT = 3'd1,
    KIND_STR   = 3'd2,
    KIND_EQ    = 3'd3,
    KIND_COMMA = 3'd4,
    KIND_SEMI  = 3'd5,
    KIND_END   = 3'd6,
    KIND_ERR   = 3'd7
  } tok_kind_e;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_UNTERM  = 2'd1,
    ERR_UNKNOWN = 2'd2
  } err_code_e;

  localparam logic [7:0] CH_END    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_EQ     = 8'h3d;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_UNDER  = 8'h5f;

  typedef struct packed {
    tok_kind_e         kind;
    logic [SPAN_W-1:0] span_start;
    logic [SPAN_W-1:0] span_end;
    err_code_e         err;
    logic              last;
  } res_t;

  function automatic logic is_ws(input logic [7:0] c);
    return c inside {8'd32, [8'd9:8'd13]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {[8'd65:8'd90], [8'd97:8'd122]};
  endfunction

  function automatic logic is_ident_tail(input logic [7:0] c);
    return is_alpha(c) || (c inside {[8'd48:8'd57]}) || (c == CH_UNDER);
  endfunction

endpackage

### sv/header_value_tokenizer_top.sv
`timescale 1ns / 1ps
// header_value_tokenizer_top: streaming lexer for header value strings
// depends on hvt_pkg

// One character beat enters per clock cycle while s_axis_tready is high. The
// lexer state (mode, token start, position, error seen) is updated in the
// cycle the beat is accepted, and the zero, one or two tokens that the
// character closes or starts are written into a four-entry result queue in
// that same cycle; results leave one beat per cycle on the master side while
// m_axis_tready is high. Input is taken whenever at most two results are
// queued, so a stalled consumer blocks intake once more than two are queued.
// Sustained rate is one character per cycle while characters give at most
// one token each and the consumer keeps up; a character giving two tokens
// (a closed identifier or whitespace run followed by a punctuation or error
// token, or the end byte after an open run) takes two beats on the output.
// Positions saturate at 2^POS_BITS-1 and are reported on 16 bits.

module header_value_tokenizer_top #(
  parameter int unsigned POS_BITS = hvt_pkg::POS_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration: skip_whitespace
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_data_i,
  // character beats
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] char_byte
  // token beats
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [2:0] token_kind, [18:3] span_start, [34:19] span_end,
  // [36:35] error_code, [39:37] zero
  output logic [hvt_pkg::M_TDATA_W-1:0] m_axis_tdata,
  output logic                          m_axis_tlast   // last_of_run
);
  import hvt_pkg::*;

  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  // lexer state
  lex_mode_e           mode_q, mode_d;
  logic [POS_BITS-1:0] tstart_q, tstart_d;
  logic [POS_BITS-1:0] pos_q, pos_d;
  err_code_e           errseen_q, errseen_d;
  logic                skip_ws_q;

  // result queue
  res_t                rq_mem_q [RQ_DEPTH];
  logic [RQ_PTR_W-1:0] rq_wr_q, rq_rd_q;
  logic [RQ_CNT_W-1:0] rq_cnt_q;

  logic                in_fire, out_fire;
  logic [7:0]          ch;
  logic [POS_BITS-1:0] pos_inc;

  // the token closed by this character and the one it produces itself
  logic                close_v, char_v, classify;
  res_t                close_r, char_r;
  res_t                push0, push1;
  logic [1:0]          push_n;

  function automatic logic [SPAN_W-1:0] to_span(input logic [POS_BITS-1:0] p);
    logic [31:0] w;
    w = 32'(p);
    return w[SPAN_W-1:0];
  endfunction

  assign cfg_ready_o   = 1'b1;
  assign ch            = s_axis_tdata;
  assign s_axis_tready = (rq_cnt_q <= RQ_CNT_W'(RQ_DEPTH - 2));
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign out_fire      = m_axis_tvalid & m_axis_tready;
  assign pos_inc       = (pos_q == POS_MAX) ? pos_q : pos_q + 1'b1;

  // lexer next state and token generation
  always_comb begin
    mode_d    = mode_q;
    tstart_d  = tstart_q;
    pos_d     = pos_q;
    errseen_d = errseen_q;
    close_v   = 1'b0;
    char_v    = 1'b0;
    classify  = 1'b0;
    close_r   = '{kind: KIND_WS, span_start: to_span(tstart_q), span_end: to_span(pos_q),
                  err: ERR_NONE, last: 1'b0};
    char_r    = '{kind: KIND_END, span_start: to_span(pos_q), span_end: to_span(pos_q),
                  err: ERR_NONE, last: 1'b0};

    if (ch == CH_END) begin
      // end byte closes any open run, then the end record
      case (mode_q)
        MODE_WS: begin
          close_v = ~skip_ws_q;
        end
        MODE_IDENT: begin
          close_v      = 1'b1;
          close_r.kind = KIND_IDENT;
        end
        MODE_STR, MODE_ESC: begin
          close_v      = 1'b1;
          close_r.kind = KIND_ERR;
          close_r.err  = ERR_UNTERM;
        end
        default: ;
      endcase
      char_v     = 1'b1;
      char_r.err = (mode_q == MODE_STR || mode_q == MODE_ESC) ? ERR_UNTERM : errseen_q;
      mode_d     = MODE_IDLE;
      tstart_d   = '0;
      pos_d      = '0;
      errseen_d  = ERR_NONE;
    end else begin
      case (mode_q)
        MODE_SKIP: begin
          pos_d = pos_inc;
        end
        MODE_STR: begin
          if (ch == CH_QUOTE) begin
            close_v          = 1'b1;
            close_r.kind     = KIND_STR;
            close_r.span_end = to_span(pos_inc);
            mode_d           = MODE_IDLE;
          end else if (ch == CH_BSLASH) begin
            mode_d = MODE_ESC;
          end
          pos_d = pos_inc;
        end
        MODE_ESC: begin
          mode_d = MODE_STR;
          pos_d  = pos_inc;
        end
        MODE_WS: begin
          if (is_ws(ch)) begin
            pos_d = pos_inc;
          end else begin
            close_v  = ~skip_ws_q;
            classify = 1'b1;
          end
        end
        MODE_IDENT: begin
          if (is_ident_tail(ch)) begin
            pos_d = pos_inc;
          end else begin
            close_v      = 1'b1;
            close_r.kind = KIND_IDENT;
            classify     = 1'b1;
          end
        end
        default: begin
          classify = 1'b1;
        end
      endcase

      if (classify) begin
        mode_d           = MODE_IDLE;
        pos_d            = pos_inc;
        char_r.span_end  = to_span(pos_inc);
        if (is_ws(ch)) begin
          mode_d   = MODE_WS;
          tstart_d = pos_q;
        end else if (is_alpha(ch)) begin
          mode_d   = MODE_IDENT;
          tstart_d = pos_q;
        end else if (ch == CH_QUOTE) begin
          mode_d   = MODE_STR;
          tstart_d = pos_q;
        end else if (ch == CH_EQ) begin
          char_v      = 1'b1;
          char_r.kind = KIND_EQ;
        end else if (ch == CH_COMMA) begin
          char_v      = 1'b1;
          char_r.kind = KIND_COMMA;
        end else if (ch == CH_SEMI) begin
          char_v      = 1'b1;
          char_r.kind = KIND_SEMI;
        end else begin
          // unknown character: report and skip to end byte
          char_v      = 1'b1;
          char_r.kind = KIND_ERR;
          char_r.err  = ERR_UNKNOWN;
          errseen_d   = ERR_UNKNOWN;
          mode_d      = MODE_SKIP;
        end
      end
    end

    if (close_v && close_r.kind == KIND_ERR) begin
      errseen_d = ERR_UNTERM;
    end
    if (ch == CH_END) begin
      errseen_d = ERR_NONE;
    end

    // compact into queue order, mark the final result of this beat
    push_n      = 2'(close_v) + 2'(char_v);
    push0       = close_v ? close_r : char_r;
    push1       = char_r;
    push0.last  = (push_n == 2'd1);
    push1.last  = 1'b1;
  end

  // lexer state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      tstart_q  <= '0;
      pos_q     <= '0;
      errseen_q <= ERR_NONE;
      skip_ws_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        skip_ws_q <= cfg_data_i;
      end
      if (in_fire) begin
        mode_q    <= mode_d;
        tstart_q  <= tstart_d;
        pos_q     <= pos_d;
        errseen_q <= errseen_d;
      end
    end
  end

  // result queue payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_fire && push_n != 2'd0) begin
      rq_mem_q[rq_wr_q] <= push0;
    end
    if (in_fire && push_n == 2'd2) begin
      rq_mem_q[rq_wr_q + 1'b1] <= push1;
    end
  end

  // result queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rq_wr_q  <= '0;
      rq_rd_q  <= '0;
      rq_cnt_q <= '0;
    end else begin
      if (in_fire) begin
        rq_wr_q <= rq_wr_q + RQ_PTR_W'(push_n);
      end
      if (out_fire) begin
        rq_rd_q <= rq_rd_q + 1'b1;
      end
      rq_cnt_q <= rq_cnt_q + (in_fire ? RQ_CNT_W'(push_n) : '0) - RQ_CNT_W'(out_fire);
    end
  end

  // output beat
  res_t head;
  assign head          = rq_mem_q[rq_rd_q];
  assign m_axis_tvalid = (rq_cnt_q != '0);
  assign m_axis_tlast  = head.last;
  assign m_axis_tdata  = {3'b000, head.err, head.span_end, head.span_start, head.kind};

endmodule

### sv/hvt_chk.sv
`timescale 1ns / 1ps
// hvt_chk: port-level assertions for the header value tokenizer
// depends on hvt_pkg; bound to header_value_tokenizer_top

module hvt_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [hvt_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic                          m_axis_tlast
);
  import hvt_pkg::*;

  logic [2:0] kind;
  logic [1:0] err;
  assign kind = m_axis_tdata[2:0];
  assign err  = m_axis_tdata[36:35];

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled token beat changed");

  // intake stalls only while results are queued
  a_stall_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty result queue");

  // end record closes the beat and has an empty span
  a_end_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && kind == KIND_END |->
      m_axis_tlast && m_axis_tdata[18:3] == m_axis_tdata[34:19])
    else $error("malformed end record");

  // error records carry a code, ordinary tokens do not
  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (kind == KIND_ERR && err != ERR_NONE) || (kind == KIND_END) ||
      (kind != KIND_ERR && err == ERR_NONE))
    else $error("error code does not match token kind");

endmodule

bind header_value_tokenizer_top hvt_chk u_hvt_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

### sim/header_value_tokenizer_top_tb.sv
`timescale 1ns / 1ps
// header_value_tokenizer_top_tb: self-checking testbench for the tokenizer top level
// depends on hvt_pkg and header_value_tokenizer_top; no files, no arguments

module header_value_tokenizer_top_tb;
  import hvt_pkg::*;

  localparam int unsigned IDLE_LIMIT  = 5000;  // cycles with no beat accepted
  localparam int unsigned DRAIN_SLACK = 8;     // cycles after the last token
  localparam int unsigned HOLD_CYCLES = 200;   // long receiver hold-off
  localparam int unsigned PHASE_ITEMS = 20;
  localparam int unsigned N_PHASES    = 5;

  // per phase: sender idle percent, receiver stall percent, skip_whitespace
  localparam int unsigned SRC_PCT [N_PHASES] = '{0, 46, 0, 14, 0};
  localparam int unsigned SNK_PCT [N_PHASES] = '{0, 0, 46, 14, 0};
  localparam bit          SKIP_VAL[N_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [15:0] POS_SAT = 16'hffff;

  typedef struct {
    logic [7:0]  ch;
    int unsigned reps;
    bit          typed;
    res_t        want;
  } dir_row_t;

  // dut ports; the inputs are known from time zero
  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic                 cfg_data_i    = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata  = 8'h00;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tlast;

  // lexer mirror state and expected tokens
  lex_mode_e   lx_mode     = MODE_IDLE;
  logic [15:0] lx_start    = '0;
  logic [15:0] lx_pos      = '0;
  err_code_e   lx_err_seen = ERR_NONE;
  logic        lx_skip_ws  = 1'b0;
  res_t        tok_expq[$];

  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned quiet_cycles = 0;
  dir_row_t    dir_rows[$];
  res_t        next_tok;

  header_value_tokenizer_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // character classes and the lexer mirror
  // ---------------------------------------------------------------------------

  function automatic bit ch_is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit ch_is_letter(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit ch_is_word(input logic [7:0] c);
    return ch_is_letter(c) || (c >= "0" && c <= "9") || (c == CH_UNDER);
  endfunction

  // chars that start a token or punctuation when seen between tokens
  function automatic bit ch_is_known(input logic [7:0] c);
    return ch_is_space(c) || ch_is_letter(c) || c == CH_QUOTE || c == CH_EQ ||
           c == CH_COMMA || c == CH_SEMI;
  endfunction

  function automatic logic [15:0] pos_inc(input logic [15:0] p);
    return (p == POS_SAT) ? p : p + 16'd1;
  endfunction

  function automatic void push_tok(input tok_kind_e k, input logic [15:0] s,
                                   input logic [15:0] e, input err_code_e er);
    res_t t;
    t.kind       = k;
    t.span_start = s;
    t.span_end   = e;
    t.err        = er;
    t.last       = 1'b0;
    tok_expq.push_back(t);
  endfunction

  // advance the mirror by one accepted char; queue the tokens it yields
  function automatic void lex_char(input logic [7:0] c);
    int unsigned n0;
    bit          open_new;
    res_t        t;
    n0 = tok_expq.size();
    open_new = 1'b1;
    if (c == CH_END) begin
      // end byte: close the open run, then the end record, back to reset
      case (lx_mode)
        MODE_WS:    if (!lx_skip_ws) push_tok(KIND_WS, lx_start, lx_pos, ERR_NONE);
        MODE_IDENT: push_tok(KIND_IDENT, lx_start, lx_pos, ERR_NONE);
        MODE_STR, MODE_ESC: begin
          push_tok(KIND_ERR, lx_start, lx_pos, ERR_UNTERM);
          lx_err_seen = ERR_UNTERM;
        end
        default: ;
      endcase
      push_tok(KIND_END, lx_pos, lx_pos, lx_err_seen);
      lx_mode     = MODE_IDLE;
      lx_start    = '0;
      lx_pos      = '0;
      lx_err_seen = ERR_NONE;
      open_new    = 1'b0;
    end else begin
      case (lx_mode)
        MODE_SKIP: begin
          lx_pos   = pos_inc(lx_pos);
          open_new = 1'b0;
        end
        MODE_STR: begin
          if (c == CH_QUOTE) begin
            push_tok(KIND_STR, lx_start, pos_inc(lx_pos), ERR_NONE);
            lx_mode = MODE_IDLE;
          end else if (c == CH_BSLASH) begin
            lx_mode = MODE_ESC;
          end
          lx_pos   = pos_inc(lx_pos);
          open_new = 1'b0;
        end
        MODE_ESC: begin
          // escaped char is plain content, the next one is checked normally
          lx_mode  = MODE_STR;
          lx_pos   = pos_inc(lx_pos);
          open_new = 1'b0;
        end
        MODE_WS: begin
          if (ch_is_space(c)) begin
            lx_pos   = pos_inc(lx_pos);
            open_new = 1'b0;
          end else begin
            if (!lx_skip_ws) push_tok(KIND_WS, lx_start, lx_pos, ERR_NONE);
            lx_mode = MODE_IDLE;
          end
        end
        MODE_IDENT: begin
          if (ch_is_word(c)) begin
            lx_pos   = pos_inc(lx_pos);
            open_new = 1'b0;
          end else begin
            push_tok(KIND_IDENT, lx_start, lx_pos, ERR_NONE);
            lx_mode = MODE_IDLE;
          end
        end
        default: lx_mode = MODE_IDLE;
      endcase
    end
    if (open_new) begin
      if (ch_is_space(c)) begin
        lx_mode  = MODE_WS;
        lx_start = lx_pos;
      end else if (ch_is_letter(c)) begin
        lx_mode  = MODE_IDENT;
        lx_start = lx_pos;
      end else if (c == CH_QUOTE) begin
        lx_mode  = MODE_STR;
        lx_start = lx_pos;
      end else if (c == CH_EQ) begin
        push_tok(KIND_EQ, lx_pos, pos_inc(lx_pos), ERR_NONE);
      end else if (c == CH_COMMA) begin
        push_tok(KIND_COMMA, lx_pos, pos_inc(lx_pos), ERR_NONE);
      end else if (c == CH_SEMI) begin
        push_tok(KIND_SEMI, lx_pos, pos_inc(lx_pos), ERR_NONE);
      end else begin
        push_tok(KIND_ERR, lx_pos, pos_inc(lx_pos), ERR_UNKNOWN);
        lx_err_seen = ERR_UNKNOWN;
        lx_mode     = MODE_SKIP;
      end
      lx_pos = pos_inc(lx_pos);
    end
    // flag the final token of this char
    if (tok_expq.size() > n0) begin
      t = tok_expq.pop_back();
      t.last = 1'b1;
      tok_expq.push_back(t);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  // token beats are sampled at the rising edge and compared in order
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (tok_expq.size() == 0) begin
        report($sformatf("token beat with nothing expected, tdata %h", m_axis_tdata));
      end else begin
        next_tok = tok_expq.pop_front();
        if (m_axis_tdata[2:0] != next_tok.kind)
          report($sformatf("kind %0d, expected %0d", m_axis_tdata[2:0], next_tok.kind));
        if (m_axis_tdata[18:3] != next_tok.span_start)
          report($sformatf("span_start %0d, expected %0d", m_axis_tdata[18:3],
                           next_tok.span_start));
        if (m_axis_tdata[34:19] != next_tok.span_end)
          report($sformatf("span_end %0d, expected %0d", m_axis_tdata[34:19],
                           next_tok.span_end));
        if (m_axis_tdata[36:35] != next_tok.err)
          report($sformatf("error_code %0d, expected %0d", m_axis_tdata[36:35],
                           next_tok.err));
        if (m_axis_tlast != next_tok.last)
          report($sformatf("tlast %0b, expected %0b", m_axis_tlast, next_tok.last));
      end
    end
  end

  // watchdog: too long without any beat on any channel ends the run
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
      $display("** header_value_tokenizer_top: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers; all are entered and left at a falling edge
  // ---------------------------------------------------------------------------

  // one char beat; a typed row replaces the mirror's single token
  task automatic send_char(input logic [7:0] c, input bit typed = 1'b0,
                           input res_t want = '0);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    lex_char(c);
    if (typed) begin
      void'(tok_expq.pop_back());
      tok_expq.push_back(want);
    end
    @(negedge clk_i);
  endtask

  // wait until every token is out, plus slack for chars that give none
  task automatic drain_tokens();
    s_axis_tvalid <= 1'b0;
    while (tok_expq.size() != 0) @(negedge clk_i);
    repeat (DRAIN_SLACK) @(negedge clk_i);
  endtask

  task automatic write_skip_ws(input logic v);
    drain_tokens();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    lx_skip_ws = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic add_row(input logic [7:0] ch, input int unsigned reps = 1,
                         input bit typed = 1'b0, input tok_kind_e k = KIND_WS,
                         input logic [15:0] s = '0, input logic [15:0] e = '0,
                         input err_code_e er = ERR_NONE);
    dir_row_t r;
    r.ch              = ch;
    r.reps            = reps;
    r.typed           = typed;
    r.want.kind       = k;
    r.want.span_start = s;
    r.want.span_end   = e;
    r.want.err        = er;
    r.want.last       = 1'b1;
    dir_rows.push_back(r);
  endtask

  function automatic logic [7:0] rand_letter();
    return $urandom_range(1) ? 8'("A" + $urandom_range(25)) : 8'("a" + $urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_word_char();
    case ($urandom_range(2))
      0:       return rand_letter();
      1:       return 8'("0" + $urandom_range(9));
      default: return CH_UNDER;
    endcase
  endfunction

  function automatic logic [7:0] rand_space();
    return $urandom_range(3) == 0 ? CH_SPACE : 8'($urandom_range(13, 9));
  endfunction

  function automatic logic [7:0] rand_unknown();
    logic [7:0] c;
    do c = 8'($urandom_range(255, 1)); while (ch_is_known(c));
    return c;
  endfunction

  // string body byte: any nonzero byte except the quote and the backslash
  function automatic logic [7:0] rand_body();
    logic [7:0] c;
    do c = 8'($urandom_range(255, 1)); while (c == CH_QUOTE || c == CH_BSLASH);
    return c;
  endfunction

  // build one header value, mostly well-formed tokens, then send it
  task automatic send_value(inout int unsigned sent);
    logic [7:0]  chars[$];
    int unsigned ntok;
    int unsigned r;
    int unsigned len;
    bit          cut;
    ntok = $urandom_range(6, 1);
    cut  = 1'b0;
    for (int unsigned i = 0; i < ntok && !cut; i++) begin
      r = $urandom_range(99);
      if (r < 25) begin
        chars.push_back(rand_letter());
        len = $urandom_range(5);
        repeat (len) chars.push_back(rand_word_char());
      end else if (r < 42) begin
        len = $urandom_range(3, 1);
        repeat (len) chars.push_back(rand_space());
      end else if (r < 62 || r >= 93) begin
        // quoted string with escapes; open-ended when r >= 93
        chars.push_back(CH_QUOTE);
        len = $urandom_range(4);
        repeat (len) begin
          if ($urandom_range(3) == 0) begin
            chars.push_back(CH_BSLASH);
            chars.push_back(8'($urandom_range(255, 1)));
          end else begin
            chars.push_back(rand_body());
          end
        end
        if (r >= 93) begin
          if ($urandom_range(1)) chars.push_back(CH_BSLASH);
          cut = 1'b1;
        end else begin
          chars.push_back(CH_QUOTE);
        end
      end else if (r < 86) begin
        case ($urandom_range(2))
          0:       chars.push_back(CH_EQ);
          1:       chars.push_back(CH_COMMA);
          default: chars.push_back(CH_SEMI);
        endcase
      end else begin
        // unknown char, the rest of the value is skipped
        chars.push_back(rand_unknown());
        len = $urandom_range(3);
        repeat (len) chars.push_back(8'($urandom_range(255, 1)));
        cut = 1'b1;
      end
    end
    chars.push_back(CH_END);
    foreach (chars[i]) send_char(chars[i]);
    sent += chars.size();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned sent;

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part, whitespace tokens on (reset value of the register)
    add_row(CH_END, 1, 1'b1, KIND_END, 16'd0, 16'd0, ERR_NONE);  // end right after reset
    add_row(CH_EQ, 1, 1'b1, KIND_EQ, 16'd0, 16'd1, ERR_NONE);
    add_row(CH_COMMA, 1, 1'b1, KIND_COMMA, 16'd1, 16'd2, ERR_NONE);
    add_row(CH_SEMI, 1, 1'b1, KIND_SEMI, 16'd2, 16'd3, ERR_NONE);
    add_row("A");                         // identifier: letters, digit, underscore
    add_row("z");
    add_row("9");
    add_row(CH_UNDER);
    add_row(CH_SPACE);                    // closes the identifier
    add_row(CH_TAB);
    add_row(CH_CR);
    add_row(CH_QUOTE);                    // closes whitespace, opens a string
    add_row("a");
    add_row(CH_BSLASH);                   // escaped quote stays content
    add_row(CH_QUOTE);
    add_row(CH_BSLASH);                   // escaped backslash, then a real close
    add_row(CH_BSLASH);
    add_row(CH_QUOTE);
    add_row(CH_END);
    add_row(8'hff, 1, 1'b1, KIND_ERR, 16'd0, 16'd1, ERR_UNKNOWN);
    add_row(8'h80);                       // ignored after the error
    add_row(CH_END, 1, 1'b1, KIND_END, 16'd2, 16'd2, ERR_UNKNOWN);
    add_row(CH_QUOTE);                    // string cut off right after a backslash
    add_row(CH_BSLASH);
    add_row(CH_END);
    add_row(CH_SPACE, 4);                 // whitespace run closed by a punctuation token
    add_row(CH_EQ);
    add_row("Z", 3);
    add_row(8'h01);                       // identifier closed by an unknown char
    add_row(CH_END);
    foreach (dir_rows[i]) begin
      repeat (dir_rows[i].reps) send_char(dir_rows[i].ch, dir_rows[i].typed, dir_rows[i].want);
    end

    // random part, one register setting and one idling pattern per phase
    for (int unsigned ph = 0; ph < N_PHASES; ph++) begin
      write_skip_ws(SKIP_VAL[ph]);
      src_idle_pct  = SRC_PCT[ph];
      snk_stall_pct = SNK_PCT[ph];
      // last phase: the receiver holds off while chars keep coming
      if (ph == N_PHASES - 1) hold_req = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        send_value(sent);
        // mixed phase: now and then let every token drain before going on
        if (ph == 3 && $urandom_range(2) == 0) drain_tokens();
      end
    end

    drain_tokens();
    if (mismatch_cnt == 0) begin
      $display("** header_value_tokenizer_top: PASSED **");
    end else begin
      $display("** header_value_tokenizer_top: FAILED **");
    end
    $finish;
  end

endmodule

### sim.f
sv/hvt_pkg.sv
sv/header_value_tokenizer_top.sv
sv/hvt_chk.sv
sim/header_value_tokenizer_top_tb.sv
